/* rtl/base64_stream_decoder_unit_defines.svh */
// Assertion macros used by the checker file of the base64 decoder.
`ifndef BASE64_STREAM_DECODER_UNIT_DEFINES_SVH
`define BASE64_STREAM_DECODER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B64D_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B64D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/b64d_pkg.sv */
package b64d_pkg;

    // Sizing defaults.
    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH        = 4;

    // Register reset value.
    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

    // Status codes carried on every result.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD      = 2'd1;
    localparam logic [1:0] STATUS_CAPACITY = 2'd2;

    // Alphabet landmarks.
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    localparam logic [7:0] LOWER_OFFSET = 8'd26;
    localparam logic [7:0] DIGIT_OFFSET = 8'd52;
    localparam logic [6:0] SEXTET_PLUS  = 7'd62;
    localparam logic [6:0] SEXTET_SLASH = 7'd63;
    localparam logic [6:0] SEXTET_BAD   = 7'd64;

    // One queued group: up to three bytes, or a status-only end result.
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  n_bytes;
        logic        last;
        logic [1:0]  status;
        logic [15:0] base_count;
    } b64d_entry_t;

    typedef struct packed {
        logic        push;
        b64d_entry_t entry;
    } b64d_push_t;

    // Maps a character to its 6-bit value; bit 6 set marks a bad character.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            v = 7'(c - CHAR_UPPER_A);
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            v = 7'(c - CHAR_LOWER_A + LOWER_OFFSET);
        else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
            v = 7'(c - CHAR_DIGIT_0 + DIGIT_OFFSET);
        else if (c == CHAR_PLUS)
            v = SEXTET_PLUS;
        else if (c == CHAR_SLASH)
            v = SEXTET_SLASH;
        else
            v = SEXTET_BAD;
        return v;
    endfunction

endpackage

/* rtl/b64d_if.sv */
// Character channel.
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] input_char;
    logic       is_last_char;

    modport source (output valid, output input_char, output is_last_char, input ready);
    modport sink   (input valid, input input_char, input is_last_char, output ready);
endinterface

// Result channel.
interface b64d_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        has_data;
    logic        end_of_string;
    logic [1:0]  status;
    logic [15:0] byte_count;

    modport source (output valid, output data_byte, output has_data, output end_of_string,
                    output status, output byte_count, input ready);
    modport sink   (input valid, input data_byte, input has_data, input end_of_string,
                    input status, input byte_count, output ready);
endinterface

/* rtl/base64_stream_decoder_unit.sv */
// Results are registered into the result queue before they are offered.
// Throughput: one character per cycle; a group's bytes leave one per cycle while
// results are taken, from a four-entry queue that stalls input only when full.
// Reset: asynchronous, active low; clears the string state and the queue,
// and sets the output capacity to 65535.
module base64_stream_decoder_unit #(
    parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    b64d_char_if.sink     chars,
    b64d_result_if.source results,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata
);

    b64d_pkg::b64d_push_t push;
    logic                 q_space;

    // Front part: classifies characters and builds groups.
    b64d_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (chars),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .q_space  (q_space),
        .push     (push)
    );

    // Back part: queues groups and emits their results.
    b64d_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .q_space(q_space),
        .results(results)
    );

endmodule

/* rtl/b64d_front.sv */
module b64d_front #(
    parameter int COUNT_BITS = b64d_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    b64d_char_if.sink           chars,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                q_space,
    output b64d_pkg::b64d_push_t push
);

    localparam int LW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

    logic [15:0]           capacity_reg;
    logic [1:0]            pos_reg, pos_next;
    logic [17:0]           acc_reg, acc_next;
    logic                  pad_reg, pad_next;
    logic [1:0]            err_reg, err_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic       accept;
    logic [6:0] v;
    logic       bad, pad, last;
    logic [5:0] v_sel;
    logic [1:0] n_bytes;
    logic [LW-1:0] limit_w, cap_w, max_w, sum_w;

    assign chars.ready = q_space;
    assign accept      = chars.valid && q_space;
    assign v           = b64d_pkg::sextet_of(chars.input_char);
    assign bad         = v[6];
    assign pad         = (chars.input_char == b64d_pkg::CHAR_PAD);
    assign last        = chars.is_last_char;

    // Effective limit is the register, clipped to what the counter can hold.
    assign cap_w   = LW'(capacity_reg);
    assign max_w   = LW'({COUNT_BITS{1'b1}});
    assign limit_w = (cap_w > max_w) ? max_w : cap_w;

    // Classify the character and update the string state.
    always_comb
    begin
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        pad_next   = pad_reg;
        err_next   = err_reg;
        count_next = count_reg;
        n_bytes    = 2'd0;
        v_sel      = v[5:0];
        sum_w      = '0;
        if (err_reg == b64d_pkg::STATUS_OK)
        begin
            case (pos_reg)
                2'd0, 2'd1:
                begin
                    if (bad)
                        err_next = b64d_pkg::STATUS_BAD;
                    else
                        acc_next = {acc_reg[11:0], v[5:0]};
                end
                2'd2:
                begin
                    if (pad)
                    begin
                        pad_next = 1'b1;
                        acc_next = {acc_reg[11:0], 6'd0};
                    end
                    else if (bad)
                        err_next = b64d_pkg::STATUS_BAD;
                    else
                        acc_next = {acc_reg[11:0], v[5:0]};
                end
                default:
                begin
                    if (pad_reg)
                    begin
                        if (!pad || !last)
                            err_next = b64d_pkg::STATUS_BAD;
                        else
                        begin
                            n_bytes = 2'd1;
                            v_sel   = 6'd0;
                        end
                    end
                    else if (pad)
                    begin
                        if (!last)
                            err_next = b64d_pkg::STATUS_BAD;
                        else
                        begin
                            n_bytes = 2'd2;
                            v_sel   = 6'd0;
                        end
                    end
                    else if (bad)
                        err_next = b64d_pkg::STATUS_BAD;
                    else
                        n_bytes = 2'd3;
                    // The whole group is dropped if it would overrun the capacity.
                    if (err_next == b64d_pkg::STATUS_OK)
                    begin
                        sum_w = LW'(count_reg) + LW'(n_bytes);
                        if (sum_w > limit_w)
                        begin
                            err_next = b64d_pkg::STATUS_CAPACITY;
                            n_bytes  = 2'd0;
                        end
                    end
                    count_next = count_reg + COUNT_BITS'(n_bytes);
                    acc_next   = '0;
                    pad_next   = 1'b0;
                end
            endcase
            if (err_next == b64d_pkg::STATUS_OK && last && pos_reg != 2'd3)
                err_next = b64d_pkg::STATUS_BAD;
            pos_next = pos_reg + 2'd1;
        end
    end

    // Hand a group to the back part when it yields any result.
    always_comb
    begin
        push.push             = accept && (n_bytes != 2'd0 || last);
        push.entry.word       = {acc_reg, v_sel};
        push.entry.n_bytes    = n_bytes;
        push.entry.last       = last;
        push.entry.status     = err_next;
        push.entry.base_count = 16'(count_reg);
    end

    // State registers; the final character returns the string state to reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= b64d_pkg::CAPACITY_RESET;
            pos_reg      <= '0;
            acc_reg      <= '0;
            pad_reg      <= 1'b0;
            err_reg      <= b64d_pkg::STATUS_OK;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                capacity_reg <= cfg_wdata;
            if (accept)
            begin
                if (last)
                begin
                    pos_reg   <= '0;
                    acc_reg   <= '0;
                    pad_reg   <= 1'b0;
                    err_reg   <= b64d_pkg::STATUS_OK;
                    count_reg <= '0;
                end
                else
                begin
                    pos_reg   <= pos_next;
                    acc_reg   <= acc_next;
                    pad_reg   <= pad_next;
                    err_reg   <= err_next;
                    count_reg <= count_next;
                end
            end
        end
    end

endmodule

/* rtl/b64d_back.sv */
module b64d_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  b64d_pkg::b64d_push_t push,
    output logic                 q_space,
    b64d_result_if.source        results
);

    localparam int DEPTH = b64d_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    b64d_pkg::b64d_entry_t queue_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    sub_reg;

    b64d_pkg::b64d_entry_t head;
    logic do_push, do_take, do_pop, status_only;

    assign q_space     = (cnt_reg != CW'(DEPTH));
    assign do_push     = push.push && q_space;
    assign head        = queue_reg[rd_ptr_reg];
    assign status_only = (head.n_bytes == 2'd0);
    assign do_take     = results.valid && results.ready;
    assign do_pop      = do_take && (status_only || sub_reg == head.n_bytes - 2'd1);

    // Present the current byte of the head group, or its status-only result.
    always_comb
    begin
        results.valid    = (cnt_reg != '0);
        results.status   = head.status;
        results.has_data = !status_only;
        case (sub_reg)
            2'd0:    results.data_byte = head.word[23:16];
            2'd1:    results.data_byte = head.word[15:8];
            default: results.data_byte = head.word[7:0];
        endcase
        if (status_only)
        begin
            results.data_byte     = 8'd0;
            results.end_of_string = 1'b1;
            results.byte_count    = head.base_count;
        end
        else
        begin
            results.end_of_string = head.last && (sub_reg == head.n_bytes - 2'd1);
            results.byte_count    = head.base_count + 16'(sub_reg) + 16'd1;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CW'(1);
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - CW'(1);
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            queue_reg[wr_ptr_reg] <= push.entry;
    end

    // Queue pointers and the byte index within the head group.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            sub_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
                sub_reg    <= '0;
            end
            else if (do_take)
                sub_reg <= sub_reg + 2'd1;
        end
    end

endmodule

/* rtl/b64d_checker.sv */
`include "base64_stream_decoder_unit_defines.svh"

module b64d_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  data_byte,
    input logic        has_data,
    input logic        end_of_string,
    input logic [1:0]  status,
    input logic [15:0] byte_count
);

    // A stalled result holds.
    `B64D_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({data_byte, has_data, end_of_string, status, byte_count}), "stalled result changed")

    // A result without a byte only ends a string.
    `B64D_ASSERT_SAME(a_status_end, clk, rst_n, out_valid && !has_data, end_of_string && data_byte == 8'd0, "status-only result not at end of string")

    // Bytes are only emitted while the string is free of errors.
    `B64D_ASSERT_SAME(a_data_ok, clk, rst_n, out_valid && has_data, status == b64d_pkg::STATUS_OK, "byte emitted with error status")

    // Within a string, a byte that directly follows a taken byte raises the count by one.
    `B64D_ASSERT_NEXT(a_count_step, clk, rst_n, out_valid && out_ready && has_data && !end_of_string, !(out_valid && has_data) || byte_count == $past(byte_count) + 16'd1, "byte count did not step by one")

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .data_byte    (results.data_byte),
    .has_data     (results.has_data),
    .end_of_string(results.end_of_string),
    .status       (results.status),
    .byte_count   (results.byte_count)
);

/* tb/b64d_decode_checker.sv */
module b64d_decode_checker
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    b64d_char_if        chars,
    b64d_result_if      results,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output int          failures,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // One decoded byte or one end-of-string status, as it should leave the block.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        has_data;
        logic        end_of_string;
        logic [1:0]  status;
        logic [15:0] byte_count;
    } b64_result_t;

    // Predicted decoder state.
    logic [15:0]  capacity_limit;
    logic [1:0]   group_pos;
    logic [17:0]  sextets;
    logic         pad_seen;
    logic [1:0]   string_status;
    logic [15:0]  decoded_total;
    b64_result_t  awaited_results[$];
    int           fail_count = 0;

    assign failures = fail_count;

    // Value of a character in the base64 alphabet; bit 6 set means not in it.
    function automatic logic [6:0] char_value(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            return 7'(c - CHAR_UPPER_A);
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            return 7'(c - CHAR_LOWER_A) + 7'd26;
        if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
            return 7'(c - CHAR_DIGIT_0) + 7'd52;
        if (c == CHAR_PLUS)
            return SEXTET_PLUS;
        if (c == CHAR_SLASH)
            return SEXTET_SLASH;
        return SEXTET_BAD;
    endfunction

    task automatic clear_string();
        group_pos     = 2'd0;
        sextets       = '0;
        pad_seen      = 1'b0;
        string_status = STATUS_OK;
        decoded_total = '0;
    endtask

    // Works out the results that one accepted character should cause.
    task automatic decode_char(input logic [7:0] c, input logic last);
        logic [6:0]  v;
        logic        pad;
        logic [1:0]  n_bytes;
        logic [23:0] word;
        int          emitted;
        b64_result_t r;
        emitted = 0;
        if (string_status == STATUS_OK) begin
            v   = char_value(c);
            pad = (c == CHAR_PAD);
            if (group_pos < 2'd2) begin
                if (v[6])
                    string_status = STATUS_BAD;
                else
                    sextets = {sextets[11:0], v[5:0]};
            end
            else if (group_pos == 2'd2) begin
                // Padding may start in the third slot; the fourth decides if it is legal.
                if (pad) begin
                    pad_seen = 1'b1;
                    sextets  = {sextets[11:0], 6'd0};
                end
                else if (v[6])
                    string_status = STATUS_BAD;
                else
                    sextets = {sextets[11:0], v[5:0]};
            end
            else begin
                n_bytes = 2'd0;
                if (pad_seen) begin
                    if (!pad || !last)
                        string_status = STATUS_BAD;
                    else begin
                        n_bytes = 2'd1;
                        v       = '0;
                    end
                end
                else if (pad) begin
                    if (!last)
                        string_status = STATUS_BAD;
                    else begin
                        n_bytes = 2'd2;
                        v       = '0;
                    end
                end
                else if (v[6])
                    string_status = STATUS_BAD;
                else
                    n_bytes = 2'd3;

                if (string_status == STATUS_OK) begin
                    word = {sextets, v[5:0]};
                    // A group that would overrun the capacity emits nothing.
                    if ({1'b0, decoded_total} + 17'(n_bytes) > {1'b0, capacity_limit})
                        string_status = STATUS_CAPACITY;
                    else begin
                        for (int i = 0; i < int'(n_bytes); i++) begin
                            decoded_total   = decoded_total + 16'd1;
                            r.data_byte     = 8'(word >> (16 - 8 * i));
                            r.has_data      = 1'b1;
                            r.end_of_string = last && (i == int'(n_bytes) - 1);
                            r.status        = string_status;
                            r.byte_count    = decoded_total;
                            awaited_results.push_back(r);
                            emitted++;
                        end
                    end
                end
                sextets  = '0;
                pad_seen = 1'b0;
            end
            // A last mark that does not close a group is a length error.
            if (string_status == STATUS_OK && last && group_pos != 2'd3)
                string_status = STATUS_BAD;
            group_pos = group_pos + 2'd1;
        end

        if (last) begin
            if (emitted == 0) begin
                r.data_byte     = 8'd0;
                r.has_data      = 1'b0;
                r.end_of_string = 1'b1;
                r.status        = string_status;
                r.byte_count    = decoded_total;
                awaited_results.push_back(r);
            end
            clear_string();
        end
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endtask

    // Compares one accepted result with the oldest prediction.
    task automatic check_result();
        b64_result_t want;
        if (awaited_results.size() == 0) begin
            $error("result with nothing awaited: data_byte %0d, status %0d, byte_count %0d",
                   results.data_byte, results.status, results.byte_count);
            fail_count++;
        end
        else begin
            want = awaited_results.pop_front();
            check_field("data_byte", 16'(want.data_byte), 16'(results.data_byte));
            check_field("has_data", 16'(want.has_data), 16'(results.has_data));
            check_field("end_of_string", 16'(want.end_of_string), 16'(results.end_of_string));
            check_field("status", 16'(want.status), 16'(results.status));
            check_field("byte_count", want.byte_count, results.byte_count);
        end
    endtask

    // Follows both channels and the capacity register.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            capacity_limit = CAPACITY_RESET;
            clear_string();
            awaited_results.delete();
            pending <= 0;
        end
        else begin
            if (results.valid && results.ready)
                check_result();
            if (chars.valid && chars.ready)
                decode_char(chars.input_char, chars.is_last_char);
            if (cfg_we)
                capacity_limit = cfg_wdata;
            pending <= awaited_results.size();
        end
    end

endmodule

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_CHARS    = 10;
    localparam int SETTLE_CYCLES  = 4;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    int          failures;
    int          pending;

    bit          idling_on;
    int          sink_hold;
    int          quiet_cycles;
    int          chars_sent;
    int          strings_sent;
    int          settings_used;
    logic [7:0]  text_q[$];

    b64d_char_if   chars_if ();
    b64d_result_if results_if ();

    base64_stream_decoder_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars_if),
        .results   (results_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    b64d_decode_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars_if),
        .results   (results_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .failures  (failures),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: ready drops in random bursts while idling is on.
    initial
    begin
        sink_hold = 0;
        results_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                sink_hold--;
                results_if.ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                sink_hold = $urandom_range(0, 5);
                results_if.ready <= 1'b0;
            end
            else
                results_if.ready <= 1'b1;
        end
    end

    // Ends the run if nothing moves on either channel for too long.
    initial quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((chars_if.valid && chars_if.ready) || (results_if.valid && results_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [7:0] base64_char(input int unsigned idx);
        if (idx < 26)
            return CHAR_UPPER_A + 8'(idx);
        if (idx < 52)
            return CHAR_LOWER_A + 8'(idx - 26);
        if (idx < 62)
            return CHAR_DIGIT_0 + 8'(idx - 52);
        if (idx == 62)
            return CHAR_PLUS;
        return CHAR_SLASH;
    endfunction

    // Sends the text queue as one string, the last mark on its final character.
    task automatic send_text();
        foreach (text_q[i])
        begin
            if (idling_on && $urandom_range(0, 4) == 0)
            begin
                chars_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            chars_if.valid        <= 1'b1;
            chars_if.input_char   <= text_q[i];
            chars_if.is_last_char <= (i == text_q.size() - 1);
            do @(posedge clk); while (!chars_if.ready);
            chars_sent++;
        end
        strings_sent++;
    endtask

    // Holds the character side off until every predicted result has come.
    task automatic wait_results_done();
        chars_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic drain();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // Mostly well-formed text with random content; about a third is damaged.
    task automatic build_text();
        int unsigned groups;
        int unsigned spot;
        groups = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
        text_q.delete();
        repeat (4 * groups) text_q.push_back(base64_char($urandom_range(0, 63)));
        case ($urandom_range(0, 2))
            1: text_q[text_q.size() - 1] = CHAR_PAD;
            2:
            begin
                text_q[text_q.size() - 1] = CHAR_PAD;
                text_q[text_q.size() - 2] = CHAR_PAD;
            end
            default: ;
        endcase
        if ($urandom_range(0, 9) < 3)
        begin
            spot = $urandom_range(0, text_q.size() - 1);
            case ($urandom_range(0, 4))
                0: text_q[spot] = CHAR_PAD;
                1: text_q[spot] = 8'($urandom_range(0, 255));
                2: repeat ($urandom_range(1, 3)) text_q.push_back(base64_char($urandom_range(0, 63)));
                3: repeat ($urandom_range(1, 3)) void'(text_q.pop_back());
                default:
                begin
                    text_q.delete();
                    repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    task automatic load_text(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    // One capacity setting followed by random strings.
    task automatic run_phase(input logic [15:0] capacity, input bit hold_off);
        int unsigned phase_chars;
        drain();
        write_capacity(capacity);
        phase_chars = 0;
        while (phase_chars < PHASE_CHARS)
        begin
            build_text();
            phase_chars += text_q.size();
            send_text();
            if (hold_off)
            begin
                wait_results_done();
                hold_off = 1'b0;
            end
        end
    endtask

    initial
    begin
        idling_on     = 1'b1;
        chars_sent    = 0;
        strings_sent  = 0;
        settings_used = 0;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_wdata             <= '0;
        chars_if.valid        <= 1'b0;
        chars_if.input_char   <= '0;
        chars_if.is_last_char <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed strings: full alphabet range, both padding forms,
        // a length error and characters outside the alphabet.
        load_text("TWFu+/9zAZa0");
        send_text();
        load_text("TQ==");
        send_text();
        load_text("TWE=");
        send_text();
        load_text("QU");
        send_text();
        text_q = '{8'h00, 8'hFF};
        send_text();

        // Random strings under a range of capacities, the extremes among them.
        run_phase(16'hFFFF, 1'b0);
        run_phase(16'd0, 1'b0);
        run_phase(16'd1, 1'b0);
        run_phase(16'd2, 1'b1);
        run_phase(16'd3, 1'b0);
        run_phase(16'd6, 1'b0);
        run_phase(16'($urandom_range(7, 200)), 1'b0);
        drain();
        idling_on = 1'b0;
        run_phase(16'hFFFF, 1'b0);
        drain();

        $display("Sent %0d strings (%0d characters) under %0d capacity settings.",
                 strings_sent, chars_sent, settings_used);
        $display("Covered both padding forms, bad characters, wrong lengths and overruns.");
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
